@@ rtl/core/sqosc_pkg.sv @@
// shared types and constants of the square oscillator with sync and phase modulation
// no dependencies; used by sqosc_front, sqosc_fifo, sqosc_back and the top level
package sqosc_pkg;

	localparam int PHASE_W = 34;   // phase accumulator, two's complement Q4.30
	localparam int CALC_W  = 36;   // working width for phase arithmetic, no overflow
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [31:0] STEP_PER_HZ_RESET = 32'd5726623;
	localparam logic [29:0] HALF_STEP = 30'h2000_0000;

	localparam logic signed [CALC_W-1:0] ONE_CYCLE  = 36'sd1073741824;
	localparam logic signed [CALC_W-1:0] HALF_CYCLE = 36'sd536870912;

	localparam logic signed [1:0] LEVEL_POS = 2'sb01;
	localparam logic signed [1:0] LEVEL_NEG = 2'sb11;

	typedef enum logic [1:0] {
		SYNC_NONE,
		SYNC_LOAD,
		SYNC_ZERO
	} sync_kind_t;

	// one classified sample, as handed from the front to the back
	typedef struct packed {
		logic               neg_f;
		logic signed [30:0] step;
		logic signed [30:0] dev;
		sync_kind_t         sync_kind;
		logic        [30:0] trig;
	} work_t;

endpackage

@@ rtl/core/sqosc_front.sv @@
// front part: takes input transactions, classifies sync, reduces the offset change
// and forms the saturated phase step through a registered multiplier; uses sqosc_pkg
module sqosc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [31:0]          step_per_hz,
	input  logic                 accept,
	input  logic signed [31:0]   frequency,
	input  logic signed [31:0]   pm_offset,
	input  logic signed [31:0]   sync_value,
	output logic                 push,
	output sqosc_pkg::work_t     push_data
);

	logic                   valid_s1, valid_s2;
	logic [31:0]            fmag_s1;
	sqosc_pkg::work_t       work_s1, work_s2;
	logic [63:0]            prod_s2;
	logic signed [31:0]     prev_offset_q;

	logic                   neg_f;
	logic [31:0]            fmag;
	logic signed [32:0]     dev_full;
	logic [32:0]            dev_abs;
	logic [29:0]            dev_mag;
	logic signed [30:0]     dev_red;
	logic                   trig_pos;
	logic                   trig_one;
	logic                   trig_le;
	sqosc_pkg::sync_kind_t  sync_kind;
	logic                   sat;
	logic [29:0]            smag;

	always_comb begin
		neg_f    = frequency[31];
		fmag     = neg_f ? (~frequency + 32'd1) : frequency;
		dev_full = {pm_offset[31], pm_offset} - {prev_offset_q[31], prev_offset_q};
		dev_abs  = dev_full[32] ? (~dev_full + 33'd1) : dev_full;
		dev_mag  = dev_abs[29:0];
		dev_red  = dev_full[32] ? -$signed({1'b0, dev_mag}) : $signed({1'b0, dev_mag});
		trig_pos = !sync_value[31] && (sync_value != 32'sd0);
		trig_one = (sync_value == 32'sd1073741824);
		trig_le  = trig_pos && (sync_value <= 32'sd1073741824);
		// negative frequency sends a sync of exactly one cycle to zero phase
		if (neg_f && trig_one) begin
			sync_kind = sqosc_pkg::SYNC_ZERO;
		end else if (trig_le) begin
			sync_kind = sqosc_pkg::SYNC_LOAD;
		end else begin
			sync_kind = sqosc_pkg::SYNC_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			prev_offset_q <= '0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			if (accept) begin
				prev_offset_q <= pm_offset;
			end
		end
	end

	// payload stages, free running: the occupancy limit keeps the queue from overflowing
	always_ff @(posedge clk) begin
		fmag_s1           <= fmag;
		work_s1.neg_f     <= neg_f;
		work_s1.step      <= '0;
		work_s1.dev       <= dev_red;
		work_s1.sync_kind <= sync_kind;
		work_s1.trig      <= sync_value[30:0];
		prod_s2           <= {32'd0, fmag_s1} * {32'd0, step_per_hz};
		work_s2           <= work_s1;
	end

	always_comb begin
		sat  = (prod_s2[63:46] != '0) || (prod_s2[45:16] > sqosc_pkg::HALF_STEP);
		smag = sat ? sqosc_pkg::HALF_STEP : prod_s2[45:16];
		push      = valid_s2;
		push_data = work_s2;
		push_data.step = work_s2.neg_f ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
	end

endmodule

@@ rtl/core/sqosc_fifo.sv @@
// short queue of classified samples between the front and the back
// uses sqosc_pkg for the entry type and depth
module sqosc_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sqosc_pkg::work_t  push_data,
	input  logic              pop,
	output logic              not_empty,
	output sqosc_pkg::work_t  head
);

	sqosc_pkg::work_t                       mem_q [sqosc_pkg::QUEUE_DEPTH];
	logic [sqosc_pkg::QUEUE_PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [sqosc_pkg::QUEUE_CNT_W-1:0]      count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

endmodule

@@ rtl/core/sqosc_back.sv @@
// back part: owns the phase accumulator, applies sync, offset change and edge rules,
// and holds the result in an output register; uses sqosc_pkg
module sqosc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 not_empty,
	input  sqosc_pkg::work_t     head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [1:0]    square_out
);

	logic [sqosc_pkg::PHASE_W-1:0]          phase_q;
	logic                                   out_valid_q;
	logic signed [1:0]                      square_q;

	logic signed [sqosc_pkg::CALC_W-1:0]    phase_x, step_x, dev_x, trig_x;
	logic signed [sqosc_pkg::CALC_W-1:0]    p_mod, p1, p2, p_next;
	logic                                   level_pos;

	always_comb begin
		phase_x = {{(sqosc_pkg::CALC_W - sqosc_pkg::PHASE_W){phase_q[sqosc_pkg::PHASE_W-1]}},
			phase_q};
		step_x  = {{(sqosc_pkg::CALC_W - 31){head.step[30]}}, head.step};
		dev_x   = {{(sqosc_pkg::CALC_W - 31){head.dev[30]}}, head.dev};
		trig_x  = {{(sqosc_pkg::CALC_W - 31){1'b0}}, head.trig};
		p_mod   = phase_x + dev_x;
		p1      = p_mod;
		p2      = p_mod;
		level_pos = 1'b1;
		if (!head.neg_f) begin
			if (head.sync_kind == sqosc_pkg::SYNC_LOAD) begin
				p1 = trig_x;
			end else if (p_mod <= 0) begin
				p1 = p_mod + sqosc_pkg::ONE_CYCLE;
			end
			// last sample of the cycle forced low, wrap forced high
			if (p1 >= sqosc_pkg::ONE_CYCLE) begin
				level_pos = 1'b1;
				p2 = p1 - sqosc_pkg::ONE_CYCLE;
			end else if (p1 + step_x >= sqosc_pkg::ONE_CYCLE) begin
				level_pos = 1'b0;
				p2 = p1;
			end else begin
				level_pos = (p1 <= sqosc_pkg::HALF_CYCLE);
				p2 = p1;
			end
		end else begin
			if (head.sync_kind == sqosc_pkg::SYNC_LOAD) begin
				p1 = trig_x;
			end else if (head.sync_kind == sqosc_pkg::SYNC_ZERO) begin
				p1 = '0;
			end else if (p_mod >= sqosc_pkg::ONE_CYCLE) begin
				p1 = p_mod - sqosc_pkg::ONE_CYCLE;
			end
			// mirrored edge rules for a falling phase
			if (p1 <= 0) begin
				level_pos = 1'b0;
				p2 = p1 + sqosc_pkg::ONE_CYCLE;
			end else if (p1 + step_x <= 0) begin
				level_pos = 1'b1;
				p2 = p1;
			end else begin
				level_pos = (p1 <= sqosc_pkg::HALF_CYCLE);
				p2 = p1;
			end
		end
		p_next = p2 + step_x;
	end

	assign pop = not_empty && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= p_next[sqosc_pkg::PHASE_W-1:0];
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			square_q <= level_pos ? sqosc_pkg::LEVEL_POS : sqosc_pkg::LEVEL_NEG;
		end
	end

	assign out_valid  = out_valid_q;
	assign square_out = square_q;

endmodule

@@ rtl/core/square_oscillator_sync_pm_top.sv @@
// top level of the square oscillator with hard sync and phase modulation
// depends on sqosc_pkg, sqosc_front, sqosc_fifo and sqosc_back
//
// one input transaction (frequency in Q24.8 Hz, phase offset and sync value in Q2.30)
// gives one output transaction carrying +1 or -1. the block takes one transaction per
// cycle and keeps that rate as long as the output side drains: out_valid rises after
// the input register, the multiply register, the queue write and the phase update.
// the front computes the step as |frequency| * step_per_hz >> 16 through one 32x32
// multiplier with a register behind it, saturates it at half a cycle, and reduces the
// offset change; classified samples wait in a four-entry queue. the back owns the
// 34-bit phase accumulator and does sync, wrap and edge forcing combinationally per
// sample, so the phase loop there sets the rate. an output register decouples the
// result from the next sample. at most four samples are held between input acceptance
// and the back, plus one in the output register, and in_ready drops when four are in
// flight.
// step_per_hz is written through cfg_we/cfg_wdata and resets to 5726623; write it
// only while no transaction is in flight.
module square_oscillator_sync_pm_top (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_we,
	input  logic [31:0]         cfg_wdata,
	// input channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  frequency,
	input  logic signed [31:0]  pm_offset,
	input  logic signed [31:0]  sync_value,
	// output channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [1:0]   square_out
);

	logic [31:0]                            step_per_hz_q;
	logic [sqosc_pkg::QUEUE_CNT_W-1:0]      inflight_q;

	logic                                   accept;
	logic                                   push;
	sqosc_pkg::work_t                       push_data;
	logic                                   pop;
	logic                                   not_empty;
	sqosc_pkg::work_t                       head;

	// step scale register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_per_hz_q <= sqosc_pkg::STEP_PER_HZ_RESET;
		end else if (cfg_we) begin
			step_per_hz_q <= cfg_wdata;
		end
	end

	// samples between input acceptance and leaving the queue; bounded by queue depth
	// so the front stages never have to stall
	assign in_ready = (inflight_q < sqosc_pkg::QUEUE_CNT_W'(sqosc_pkg::QUEUE_DEPTH));
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (accept && !pop) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (pop && !accept) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	// classify and form the step
	sqosc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_per_hz  (step_per_hz_q),
		.accept       (accept),
		.frequency    (frequency),
		.pm_offset    (pm_offset),
		.sync_value   (sync_value),
		.push         (push),
		.push_data    (push_data)
	);

	// decoupling queue
	sqosc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	// phase accumulator and output register
	sqosc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.not_empty  (not_empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.square_out (square_out)
	);

endmodule
